// ===== design/rgd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgd_pkg
// Types, codes and constants of the RDS group decoder.
// ----------------------------------------------------------------------------
package rgd_pkg;

	localparam logic [4:0] GT_NAME_A = 5'h00;
	localparam logic [4:0] GT_NAME_B = 5'h01;
	localparam logic [4:0] GT_TEXT   = 5'h04;
	localparam logic [4:0] GT_CLOCK  = 5'h08;

	localparam logic [1:0]  ERR_NONE       = 2'd0;
	localparam logic [7:0]  CHAR_SPACE     = 8'h20;
	localparam logic [16:0] MIN_SHOW_LIMIT = 17'd1500;
	localparam logic [11:0] RECIP_60       = 12'd2185;
	localparam int          RECIP_SHIFT    = 17;

	typedef struct packed {
		logic [15:0] group_block_b;
		logic [15:0] group_block_c;
		logic [15:0] group_block_d;
		logic [1:0]  block_error;
		logic        rds_synced;
	} group_t;

	typedef struct packed {
		logic [63:0] station_name;
		logic [4:0]  clock_hours;
		logic [5:0]  clock_minutes;
		logic        time_shown;
		logic        text_updated;
		logic [2:0]  chunk_index;
		logic [63:0] text_chunk;
		logic        last_result;
	} result_t;

	typedef struct packed {
		logic strobe;
		logic clear;
		logic name_en;
		logic clock_en;
		logic err_ok;
	} info_ctl_t;

	typedef struct packed {
		logic [63:0] name;
		logic [4:0]  hours;
		logic [5:0]  minutes;
		logic        shown;
	} info_stat_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_PUB_RD,
		ST_PUB_CHK,
		ST_PUB_WR,
		ST_FINISH,
		ST_OUT_RD,
		ST_OUT_SEND
	} state_t;

	function automatic logic printable(input logic [7:0] c);
		return (c > 8'd31) && (c < 8'd127);
	endfunction

endpackage

// ===== design/rgd_group_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgd_group_if
// Input channel: one RDS group per item.
// ----------------------------------------------------------------------------
interface rgd_group_if;
	logic        valid;
	logic        ready;
	logic [15:0] group_block_b;
	logic [15:0] group_block_c;
	logic [15:0] group_block_d;
	logic [1:0]  block_error;
	logic        rds_synced;

	modport source (output valid, group_block_b, group_block_c, group_block_d,
		block_error, rds_synced, input ready);
	modport sink (input valid, group_block_b, group_block_c, group_block_d,
		block_error, rds_synced, output ready);
endinterface

// ===== design/rgd_result_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgd_result_if
// Output channel: one decoded result per item.
// ----------------------------------------------------------------------------
interface rgd_result_if;
	logic        valid;
	logic        ready;
	logic [63:0] station_name;
	logic [4:0]  clock_hours;
	logic [5:0]  clock_minutes;
	logic        time_shown;
	logic        text_updated;
	logic [2:0]  chunk_index;
	logic [63:0] text_chunk;
	logic        last_result;

	modport source (output valid, station_name, clock_hours, clock_minutes,
		time_shown, text_updated, chunk_index, text_chunk, last_result, input ready);
	modport sink (input valid, station_name, clock_hours, clock_minutes,
		time_shown, text_updated, chunk_index, text_chunk, last_result, output ready);
endinterface

// ===== design/rds_group_decoder_top.sv =====
`timescale 1ns / 1ps
// A group passes through decode, an optional publish pass over the collected radiotext
// characters, finish and the result read-out before its first result is offered.
// A changed text walks the 64-byte shown-text RAM, with one result hand-off per chunk.
// One group at a time: a new group is taken only after the last result of the previous one.
// Reset clears all state at once through valid bits; no clearing pass.
// ----------------------------------------------------------------------------
// rds_group_decoder_top
// RDS group decoder: station name, radiotext and clock time.
// ----------------------------------------------------------------------------
module rds_group_decoder_top (
	input logic         clk,
	input logic         arst_n,
	rgd_group_if.sink   grp,
	rgd_result_if.source res
);
	rgd_pkg::state_t     state_q, state_d;
	rgd_pkg::group_t     grp_q;
	rgd_pkg::result_t    res_q;
	rgd_pkg::info_ctl_t  ctl;
	rgd_pkg::info_stat_t stat;

	logic        res_valid_q;
	logic [15:0] col_vld_q;
	logic [63:0] shw_vld_q;
	logic [3:0]  last_pos_q;
	logic        last_ab_q;
	logic        any_nz_q;
	logic        changed_q;
	logic [6:0]  pub_i_q;
	logic [6:0]  pub_n_q;
	logic [7:0]  char_q;
	logic [2:0]  chunk_q;
	logic [3:0]  byte_q;
	logic [55:0] sr_q;
	logic [3:0]  col_rd_q;
	logic [5:0]  shw_rd_q;

	logic        col_we, shw_we;
	logic [3:0]  col_raddr;
	logic [31:0] col_rdata;
	logic [5:0]  shw_raddr;
	logic [7:0]  shw_rdata;
	logic [7:0]  col_byte;
	logic [7:0]  shw_old;
	logic [4:0]  gtype;
	logic        is_text;
	logic [3:0]  text_idx;
	logic        ab;
	logic        do_pub;
	logic [15:0] col_vld_kept;

	assign gtype    = grp_q.group_block_b[15:11];
	assign is_text  = (gtype == rgd_pkg::GT_TEXT);
	assign text_idx = grp_q.group_block_b[3:0];
	assign ab       = grp_q.group_block_b[4];
	assign do_pub   = is_text && grp_q.rds_synced && (text_idx < last_pos_q)
		&& (ab == last_ab_q);
	assign col_vld_kept = (ab != last_ab_q) ? 16'd0 : col_vld_q;

	assign col_raddr = pub_i_q[5:2];

	always_comb begin
		case (pub_i_q[1:0])
			2'd0:    col_byte = col_rdata[31:24];
			2'd1:    col_byte = col_rdata[23:16];
			2'd2:    col_byte = col_rdata[15:8];
			default: col_byte = col_rdata[7:0];
		endcase
		if (!col_vld_q[col_rd_q]) begin
			col_byte = 8'd0;
		end
		shw_old = shw_vld_q[shw_rd_q] ? shw_rdata : 8'd0;
	end

	rgd_ram #(.WIDTH(32), .DEPTH(16)) u_collect (
		.clk   (clk),
		.we    (col_we),
		.waddr (text_idx),
		.wdata ({grp_q.group_block_c, grp_q.group_block_d}),
		.raddr (col_raddr),
		.rdata (col_rdata)
	);

	rgd_ram #(.WIDTH(8), .DEPTH(64)) u_shown (
		.clk   (clk),
		.we    (shw_we),
		.waddr (pub_n_q[5:0]),
		.wdata (char_q),
		.raddr (shw_raddr),
		.rdata (shw_rdata)
	);

	rgd_info u_info (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.blk_b  (grp_q.group_block_b),
		.blk_c  (grp_q.group_block_c),
		.blk_d  (grp_q.group_block_d),
		.stat   (stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rgd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		col_we       = 1'b0;
		shw_we       = 1'b0;
		shw_raddr    = pub_n_q[5:0];
		ctl          = '0;
		unique case (state_q)
			rgd_pkg::ST_IDLE: begin
				if (grp.valid) begin
					state_d = rgd_pkg::ST_DECODE;
				end
			end
			rgd_pkg::ST_DECODE: begin
				ctl.strobe   = 1'b1;
				ctl.clear    = !grp_q.rds_synced;
				ctl.name_en  = (gtype == rgd_pkg::GT_NAME_A) || (gtype == rgd_pkg::GT_NAME_B);
				ctl.clock_en = (gtype == rgd_pkg::GT_CLOCK);
				ctl.err_ok   = (grp_q.block_error == rgd_pkg::ERR_NONE);
				state_d      = do_pub ? rgd_pkg::ST_PUB_RD : rgd_pkg::ST_FINISH;
			end
			rgd_pkg::ST_PUB_RD: begin
				state_d = pub_i_q[6] ? rgd_pkg::ST_FINISH : rgd_pkg::ST_PUB_CHK;
			end
			rgd_pkg::ST_PUB_CHK: begin
				if (col_byte == 8'd0) begin
					state_d = rgd_pkg::ST_FINISH;
				end else if (rgd_pkg::printable(col_byte)) begin
					state_d = rgd_pkg::ST_PUB_WR;
				end else begin
					state_d = rgd_pkg::ST_PUB_RD;
				end
			end
			rgd_pkg::ST_PUB_WR: begin
				shw_we  = 1'b1;
				state_d = rgd_pkg::ST_PUB_RD;
			end
			rgd_pkg::ST_FINISH: begin
				col_we  = is_text && (grp_q.block_error == rgd_pkg::ERR_NONE);
				state_d = rgd_pkg::ST_OUT_RD;
			end
			rgd_pkg::ST_OUT_RD: begin
				shw_raddr = {chunk_q, byte_q[2:0]};
				if (!changed_q || byte_q[3]) begin
					state_d = rgd_pkg::ST_OUT_SEND;
				end
			end
			rgd_pkg::ST_OUT_SEND: begin
				if (res.ready) begin
					state_d = res_q.last_result ? rgd_pkg::ST_IDLE : rgd_pkg::ST_OUT_RD;
				end
			end
			default: state_d = rgd_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_q       <= '0;
			res_q       <= '0;
			res_valid_q <= 1'b0;
			col_vld_q   <= '0;
			shw_vld_q   <= '0;
			last_pos_q  <= '0;
			last_ab_q   <= 1'b0;
			any_nz_q    <= 1'b0;
			changed_q   <= 1'b0;
			pub_i_q     <= '0;
			pub_n_q     <= '0;
			char_q      <= '0;
			chunk_q     <= '0;
			byte_q      <= '0;
			sr_q        <= '0;
			col_rd_q    <= '0;
			shw_rd_q    <= '0;
		end else begin
			col_rd_q <= col_raddr;
			shw_rd_q <= shw_raddr;
			case (state_q)
				rgd_pkg::ST_IDLE: begin
					if (grp.valid) begin
						grp_q.group_block_b <= grp.group_block_b;
						grp_q.group_block_c <= grp.group_block_c;
						grp_q.group_block_d <= grp.group_block_d;
						grp_q.block_error   <= grp.block_error;
						grp_q.rds_synced    <= grp.rds_synced;
					end
				end
				rgd_pkg::ST_DECODE: begin
					pub_i_q <= '0;
					pub_n_q <= '0;
					chunk_q <= '0;
					byte_q  <= '0;
					if (!grp_q.rds_synced) begin
						col_vld_q  <= '0;
						shw_vld_q  <= '0;
						last_pos_q <= '0;
						any_nz_q   <= 1'b0;
						changed_q  <= any_nz_q;
					end else begin
						changed_q <= 1'b0;
					end
				end
				rgd_pkg::ST_PUB_CHK: begin
					if (col_byte != 8'd0) begin
						if (rgd_pkg::printable(col_byte)) begin
							char_q <= col_byte;
						end else begin
							pub_i_q <= pub_i_q + 7'd1;
						end
					end
				end
				rgd_pkg::ST_PUB_WR: begin
					if (shw_old != char_q) begin
						changed_q <= 1'b1;
					end
					shw_vld_q[pub_n_q[5:0]] <= 1'b1;
					any_nz_q <= 1'b1;
					pub_n_q  <= pub_n_q + 7'd1;
					pub_i_q  <= pub_i_q + 7'd1;
				end
				rgd_pkg::ST_FINISH: begin
					if (is_text) begin
						last_pos_q <= text_idx;
						if (ab != last_ab_q) begin
							last_ab_q <= ab;
							shw_vld_q <= '0;
							any_nz_q  <= 1'b0;
							changed_q <= changed_q | any_nz_q;
						end
						if (grp_q.block_error == rgd_pkg::ERR_NONE) begin
							col_vld_q <= col_vld_kept | (16'd1 << text_idx);
						end else begin
							col_vld_q <= col_vld_kept;
						end
					end
				end
				rgd_pkg::ST_OUT_RD: begin
					byte_q <= byte_q + 4'd1;
					if (byte_q != 4'd0) begin
						sr_q <= {sr_q[47:0], shw_old};
					end
					if (!changed_q || byte_q[3]) begin
						res_valid_q         <= 1'b1;
						res_q.station_name  <= stat.name;
						res_q.clock_hours   <= stat.hours;
						res_q.clock_minutes <= stat.minutes;
						res_q.time_shown    <= stat.shown;
						res_q.text_updated  <= changed_q;
						res_q.chunk_index   <= changed_q ? chunk_q : 3'd0;
						res_q.text_chunk    <= changed_q ? {sr_q, shw_old} : 64'd0;
						res_q.last_result   <= !changed_q || (chunk_q == 3'd7);
					end
				end
				rgd_pkg::ST_OUT_SEND: begin
					if (res.ready) begin
						res_valid_q <= 1'b0;
						chunk_q     <= chunk_q + 3'd1;
						byte_q      <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	assign grp.ready         = (state_q == rgd_pkg::ST_IDLE);
	assign res.valid         = res_valid_q;
	assign res.station_name  = res_q.station_name;
	assign res.clock_hours   = res_q.clock_hours;
	assign res.clock_minutes = res_q.clock_minutes;
	assign res.time_shown    = res_q.time_shown;
	assign res.text_updated  = res_q.text_updated;
	assign res.chunk_index   = res_q.chunk_index;
	assign res.text_chunk    = res_q.text_chunk;
	assign res.last_result   = res_q.last_result;

`ifndef SYNTHESIS
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> !grp.ready)
		else $error("result pending while a group is accepted");
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && !res.text_updated) |-> res.last_result)
		else $error("unchanged text result is not last");
	a_chunk_last: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.text_updated && res.chunk_index == 3'd7) |-> res.last_result)
		else $error("final chunk not marked last");
	a_dashes: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && !res.time_shown) |-> (res.clock_hours == 5'd0 && res.clock_minutes == 6'd0))
		else $error("time fields set while no time shown");
`endif
endmodule

// ===== design/rgd_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgd_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module rgd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== design/rgd_info.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgd_info
// Program-service name copies and clock-time state with hour/minute split.
// ----------------------------------------------------------------------------
module rgd_info (
	input  logic                clk,
	input  logic                arst_n,
	input  rgd_pkg::info_ctl_t  ctl,
	input  logic [15:0]         blk_b,
	input  logic [15:0]         blk_c,
	input  logic [15:0]         blk_d,
	output rgd_pkg::info_stat_t stat
);
	logic [7:0]  first_q  [8];
	logic [7:0]  second_q [8];
	logic [7:0]  shown_q  [8];
	logic [7:0]  first_d  [8];
	logic [7:0]  second_d [8];
	logic [7:0]  shown_d  [8];
	logic [5:0]  zone_q;
	logic [15:0] minute_q;
	logic [10:0] time_q;
	logic        time_valid_q;
	logic [4:0]  hours_q;

	logic [2:0]  pos;
	logic [3:0]  n;
	logic [5:0]  zone_d;
	logic [16:0] m_base;
	logic [16:0] adj;
	logic [16:0] m_new;
	logic [15:0] m_sat;
	logic        show;
	logic [22:0] prod;

	always_comb begin
		first_d  = first_q;
		second_d = second_q;
		shown_d  = shown_q;
		n        = 4'd0;
		pos      = {blk_b[1:0], 1'b0};
		if (ctl.clear) begin
			for (int i = 0; i < 8; i++) begin
				first_d[i]  = rgd_pkg::CHAR_SPACE;
				second_d[i] = rgd_pkg::CHAR_SPACE;
				shown_d[i]  = rgd_pkg::CHAR_SPACE;
			end
		end
		if (ctl.name_en) begin
			if (first_d[pos] == blk_d[15:8] && first_d[pos | 3'd1] == blk_d[7:0]) begin
				second_d[pos]        = blk_d[15:8];
				second_d[pos | 3'd1] = blk_d[7:0];
				if (first_d == second_d) begin
					for (int i = 0; i < 8; i++) begin
						if (rgd_pkg::printable(second_d[i])) begin
							shown_d[n[2:0]] = second_d[i];
							n = n + 4'd1;
						end
					end
				end
			end else begin
				first_d[pos]        = blk_d[15:8];
				first_d[pos | 3'd1] = blk_d[7:0];
			end
		end
	end

	always_comb begin
		zone_d = ctl.err_ok ? blk_d[5:0] : zone_q;
		m_base = ctl.clear ? 17'd0 : {1'b0, minute_q};
		if (ctl.err_ok) begin
			m_base = {11'd0, blk_d[11:6]}
				+ ({12'd0, blk_c[0], blk_d[15:12]} << 6)
				- ({12'd0, blk_c[0], blk_d[15:12]} << 2);
		end
		adj = ({12'd0, zone_d[4:0]} << 5) - ({12'd0, zone_d[4:0]} << 1);
		if (zone_d[5]) begin
			m_new = (m_base > adj) ? (m_base - adj) : 17'd0;
		end else begin
			m_new = m_base + adj;
		end
		m_sat = m_new[16] ? 16'hFFFF : m_new[15:0];
		show  = (m_new != 17'd0) && (m_new < rgd_pkg::MIN_SHOW_LIMIT);
		prod  = {12'd0, time_q} * {11'd0, rgd_pkg::RECIP_60};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				first_q[i]  <= rgd_pkg::CHAR_SPACE;
				second_q[i] <= rgd_pkg::CHAR_SPACE;
				shown_q[i]  <= rgd_pkg::CHAR_SPACE;
			end
			zone_q       <= '0;
			minute_q     <= '0;
			time_q       <= '0;
			time_valid_q <= 1'b0;
			hours_q      <= '0;
		end else begin
			hours_q <= 5'(prod >> rgd_pkg::RECIP_SHIFT);
			if (ctl.strobe) begin
				first_q  <= first_d;
				second_q <= second_d;
				shown_q  <= shown_d;
				if (ctl.clear) begin
					minute_q     <= '0;
					time_q       <= '0;
					time_valid_q <= 1'b0;
				end
				if (ctl.clock_en) begin
					zone_q   <= zone_d;
					minute_q <= m_sat;
					if (show) begin
						time_q       <= m_new[10:0];
						time_valid_q <= 1'b1;
					end
				end
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			stat.name[63-8*i -: 8] = shown_q[i];
		end
		stat.shown   = time_valid_q;
		stat.hours   = time_valid_q ? hours_q : 5'd0;
		stat.minutes = time_valid_q ? 6'(time_q - ((11'(hours_q) << 6) - (11'(hours_q) << 2)))
			: 6'd0;
	end
endmodule
